[sv/ttts_pkg.sv]
// ----------------------------------------------------------------------------
// ttts_pkg
// Shared widths, codes and reset values for the two-track tone sequencer.
// ----------------------------------------------------------------------------
package ttts_pkg;

   // Default store depth in pairs
   localparam int TRACK_PAIRS_DEF = 512;

   // Field widths
   localparam int OP_W        = 3;
   localparam int INDEX_W     = 9;
   localparam int TONE_W      = 8;
   localparam int HOLD_W      = 8;
   localparam int COUNT_W     = 10;
   localparam int PAIR_W      = TONE_W + HOLD_W;
   localparam int TONE_BASE_W = 21;
   localparam int DIVISOR_W   = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = TONE_BASE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_BASE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_DIVISOR = 1'b1;

   // Register reset values: base is the 1193180 Hz timer clock over 8
   localparam logic [TONE_BASE_W-1:0] TONE_BASE_RST    = TONE_BASE_W'(1193180 / 8);
   localparam logic [DIVISOR_W-1:0]   REST_DIVISOR_RST = DIVISOR_W'(13528);

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE_BG = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE_FX = 3'd2;
   localparam logic [OP_W-1:0] OP_START_BG = 3'd3;
   localparam logic [OP_W-1:0] OP_START_FX = 3'd4;

   // Serial divider iteration counter
   localparam int DIV_CNT_W = $clog2(TONE_BASE_W);

endpackage

[sv/ttts_ram.sv]
// ----------------------------------------------------------------------------
// ttts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/two_track_tone_sequencer.sv]
// ----------------------------------------------------------------------------
// two_track_tone_sequencer
// Plays background and effect note lists out of two pair stores and drives
// a tone timer divisor and speaker gate, one result per transaction.
// ----------------------------------------------------------------------------
//
//  channel   ports                               handshake
//  -------   ---------------------------------   -------------------------------
//  request   req_* fields                        taken when start && !busy
//  response  rsp_* fields                        one-cycle rsp_valid strobe
//  csr       csr_index, csr_write_data           written when csr_write_en
//
//  A tick that loads or re-drives a tone runs: a store read (S_LOAD), a
//  21-step restoring divide (tone_base / tone, one quotient bit per cycle) and
//  an update (S_FINISH) that fires rsp_valid; a rest skips the divide.
//  Every other transaction answers in the cycle after accept. busy is low in
//  the rsp_valid cycle, so a new transaction may be taken there.
//  Reset is synchronous and clears all track state; the stores are not cleared.
//  The receiver cannot stall: each result shows for exactly one cycle.
//
module two_track_tone_sequencer #(
   parameter int TRACK_PAIRS = ttts_pkg::TRACK_PAIRS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   // request channel
   input  logic                               start,
   output logic                               busy,
   input  logic [ttts_pkg::OP_W-1:0]          req_operation,
   input  logic [ttts_pkg::INDEX_W-1:0]       req_pair_index,
   input  logic [ttts_pkg::TONE_W-1:0]        req_tone_code,
   input  logic [ttts_pkg::HOLD_W-1:0]        req_hold_ticks,
   input  logic [ttts_pkg::COUNT_W-1:0]       req_pair_count,
   input  logic                               req_loop_flag,

   // response channel
   output logic                               rsp_valid,
   output logic [ttts_pkg::DIVISOR_W-1:0]     rsp_timer_divisor,
   output logic                               rsp_speaker_on,
   output logic                               rsp_effect_active,
   output logic                               rsp_background_active,

   // configuration registers
   input  logic                               csr_write_en,
   input  logic [ttts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ttts_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   import ttts_pkg::*;

   // Store address, and position/length width (position may equal the depth)
   localparam int ADDR_W = $clog2(TRACK_PAIRS);
   localparam int POS_W  = $clog2(TRACK_PAIRS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,     // store read data arrives
      S_DIVIDE,   // one quotient bit per cycle
      S_FINISH    // commit track update, fire response
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [TONE_BASE_W-1:0] tone_base_ff;
   logic [DIVISOR_W-1:0]   rest_div_ff;

   // Track state
   logic [POS_W-1:0]  bg_pos_ff, bg_len_ff, fx_pos_ff, fx_len_ff;
   logic [HOLD_W-1:0] bg_hold_ff, fx_hold_ff;
   logic              bg_repeat_ff;
   logic              gate_ff;
   logic [DIVISOR_W-1:0] divisor_ff;
   logic              rsp_valid_ff;

   // Per-tick context latched at accept
   logic              sel_fx_ff;    // tick serves effect track
   logic              load_ff;      // hold was zero: load next pair
   logic              pos_zero_ff;  // re-drive with no previous pair
   logic [TONE_W-1:0] tone_ff;
   logic [HOLD_W-1:0] new_hold_ff;

   // Serial divider
   logic [TONE_BASE_W-1:0] quot_ff;
   logic [TONE_W-1:0]      rem_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;

   // ---- request decode -----------------------------------------------------
   logic                accept;
   logic                idx_in_range;
   logic [POS_W-1:0]    count_sat;
   logic [31:0]         count_wide;
   logic [ADDR_W-1:0]   wr_addr;
   logic [PAIR_W-1:0]   wr_pair;
   logic                bg_wr_en, fx_wr_en;

   assign accept       = start && !busy;
   assign idx_in_range = 32'(req_pair_index) < TRACK_PAIRS;
   assign count_wide   = (32'(req_pair_count) > TRACK_PAIRS) ? TRACK_PAIRS
                                                            : 32'(req_pair_count);
   assign count_sat    = count_wide[POS_W-1:0];
   assign wr_addr      = ADDR_W'(req_pair_index);
   assign wr_pair      = {req_tone_code, req_hold_ticks};
   assign bg_wr_en     = accept && (req_operation == OP_WRITE_BG) && idx_in_range;
   assign fx_wr_en     = accept && (req_operation == OP_WRITE_FX) && idx_in_range;

   // ---- served track view --------------------------------------------------
   logic              sel_fx;
   logic [POS_W-1:0]  cur_pos, cur_len, cur_pos_dec;
   logic [HOLD_W-1:0] cur_hold;
   logic              cur_running;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;

   always_comb begin
      sel_fx      = fx_len_ff != '0;
      cur_pos     = sel_fx ? fx_pos_ff  : bg_pos_ff;
      cur_len     = sel_fx ? fx_len_ff  : bg_len_ff;
      cur_hold    = sel_fx ? fx_hold_ff : bg_hold_ff;
      cur_pos_dec = cur_pos - POS_W'(1);
      cur_running = (cur_pos < cur_len) || ((cur_pos == cur_len) && (cur_hold != '0));
      // hold zero reads the pair at position, else the one before it
      rd_addr     = (cur_hold == '0) ? cur_pos[ADDR_W-1:0] : cur_pos_dec[ADDR_W-1:0];
      rd_en       = accept && (req_operation == OP_TICK);
   end

   // ---- pair stores --------------------------------------------------------
   logic [PAIR_W-1:0] bg_rdata, fx_rdata;

   ttts_ram #(.WIDTH(PAIR_W), .DEPTH(TRACK_PAIRS)) u_bg_ram (
      .clock   (clock),
      .wr_en   (bg_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_pair),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (bg_rdata)
   );

   ttts_ram #(.WIDTH(PAIR_W), .DEPTH(TRACK_PAIRS)) u_fx_ram (
      .clock   (clock),
      .wr_en   (fx_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_pair),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (fx_rdata)
   );

   // ---- load / divide datapath ---------------------------------------------
   logic [PAIR_W-1:0] pair_data;
   logic [TONE_W-1:0] load_tone;
   logic [TONE_W:0]   trial;
   logic              trial_ge;
   logic [TONE_W:0]   trial_diff;
   logic [DIVISOR_W-1:0] quot_sat;

   always_comb begin
      pair_data  = sel_fx_ff ? fx_rdata : bg_rdata;
      // re-drive at position zero has no pair behind it: treat as rest
      load_tone  = (load_ff || !pos_zero_ff) ? pair_data[PAIR_W-1:HOLD_W] : '0;
      trial      = {rem_ff, quot_ff[TONE_BASE_W-1]};
      trial_ge   = trial >= {1'b0, tone_ff};
      trial_diff = trial - {1'b0, tone_ff};
      // quotient above the timer range pins at full scale
      quot_sat   = (quot_ff[TONE_BASE_W-1:DIVISOR_W] != '0) ? '1
                                                           : quot_ff[DIVISOR_W-1:0];
   end

   // ---- sequencer, track state and registered outputs ----------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tone_base_ff <= TONE_BASE_RST;
         rest_div_ff  <= REST_DIVISOR_RST;
         bg_pos_ff    <= '0;
         bg_len_ff    <= '0;
         bg_hold_ff   <= '0;
         bg_repeat_ff <= 1'b0;
         fx_pos_ff    <= '0;
         fx_len_ff    <= '0;
         fx_hold_ff   <= '0;
         gate_ff      <= 1'b0;
         divisor_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         if (csr_write_en) begin
            case (csr_index)
               CSR_TONE_BASE:    tone_base_ff <= csr_write_data;
               CSR_REST_DIVISOR: rest_div_ff  <= csr_write_data[DIVISOR_W-1:0];
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_operation)
                     OP_TICK: begin
                        sel_fx_ff   <= sel_fx;
                        load_ff     <= cur_hold == '0;
                        pos_zero_ff <= cur_pos == '0;
                        if (cur_running) begin
                           state_ff <= S_LOAD;
                        end else begin
                           // track end
                           rsp_valid_ff <= 1'b1;
                           if (sel_fx) begin
                              fx_len_ff <= '0;
                           end else if (bg_repeat_ff) begin
                              bg_pos_ff <= '0;
                           end else begin
                              bg_len_ff <= '0;
                              gate_ff   <= 1'b0;
                           end
                        end
                     end
                     OP_START_BG: begin
                        bg_len_ff    <= count_sat;
                        bg_repeat_ff <= req_loop_flag;
                        bg_pos_ff    <= '0;
                        bg_hold_ff   <= '0;
                        gate_ff      <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end
                     OP_START_FX: begin
                        fx_len_ff    <= count_sat;
                        fx_pos_ff    <= '0;
                        fx_hold_ff   <= '0;
                        gate_ff      <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end
                     default: begin
                        // store writes and unknown codes only report
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end

            S_LOAD: begin
               tone_ff     <= load_tone;
               new_hold_ff <= pair_data[HOLD_W-1:0];
               quot_ff     <= tone_base_ff;
               rem_ff      <= '0;
               cnt_ff      <= DIV_CNT_W'(TONE_BASE_W - 1);
               state_ff    <= (load_tone == '0) ? S_FINISH : S_DIVIDE;
            end

            S_DIVIDE: begin
               rem_ff   <= trial_ge ? trial_diff[TONE_W-1:0] : trial[TONE_W-1:0];
               quot_ff  <= {quot_ff[TONE_BASE_W-2:0], trial_ge};
               cnt_ff   <= cnt_ff - DIV_CNT_W'(1);
               if (cnt_ff == '0) begin
                  state_ff <= S_FINISH;
               end
            end

            S_FINISH: begin
               divisor_ff   <= (tone_ff == '0) ? rest_div_ff : quot_sat;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
               if (load_ff) begin
                  gate_ff <= tone_ff != '0;
                  if (sel_fx_ff) begin
                     fx_pos_ff  <= fx_pos_ff + POS_W'(1);
                     fx_hold_ff <= new_hold_ff;
                  end else begin
                     bg_pos_ff  <= bg_pos_ff + POS_W'(1);
                     bg_hold_ff <= new_hold_ff;
                  end
               end else if (sel_fx_ff) begin
                  fx_hold_ff <= fx_hold_ff - HOLD_W'(1);
               end else begin
                  bg_hold_ff <= bg_hold_ff - HOLD_W'(1);
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy                  = state_ff != S_IDLE;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_timer_divisor     = divisor_ff;
   assign rsp_speaker_on        = gate_ff;
   assign rsp_effect_active     = fx_len_ff != '0;
   assign rsp_background_active = bg_len_ff != '0;

`ifndef ASSERT_OFF
   // an accepted transaction either starts work or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   // results only come out once the sequencer is back to idle
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // divider never runs on a zero tone
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (tone_ff != '0))
      else $error("divide by zero tone");

   // track lengths never pass the store depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(bg_len_ff) <= TRACK_PAIRS) && (32'(fx_len_ff) <= TRACK_PAIRS))
      else $error("track length beyond store depth");
`endif

endmodule

[sim/tb_two_track_tone_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_two_track_tone_sequencer
// Self-checking bench for the two-track tone sequencer: a directed table,
// then random songs, noise and setting changes, scored against an in-bench
// model of the sequencer or typed expectations. A tick about to take a pair
// that was never written is preceded by a write of that pair.
// ----------------------------------------------------------------------------
module tb_two_track_tone_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import ttts_pkg::*;

   // Bench constants
   localparam int          NUM_PAIRS     = TRACK_PAIRS_DEF;
   localparam int          BG_TRACK      = 0;
   localparam int          FX_TRACK      = 1;
   localparam int          RANDOM_ITEMS  = 375;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          TAIL_CYCLES   = 40;
   localparam int          SETTING_EVERY = 80;
   localparam int          TONE_BASE_MAX = 1193180;
   localparam int          DIV_SAT       = 65535;
   // Codes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   // One request transaction, one field per port
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] idx;
      logic [TONE_W-1:0]  tone;
      logic [HOLD_W-1:0]  hold;
      logic [COUNT_W-1:0] count;
      logic               loop_en;
   } tone_req_type;

   // One response transaction
   typedef struct packed {
      logic [DIVISOR_W-1:0] divisor;
      logic                 speaker;
      logic                 fx_active;
      logic                 bg_active;
   } tone_state_type;

   typedef struct {
      tone_req_type   req;
      bit             has_exp;
      tone_state_type exp;
   } stim_row_type;

   // ---------------------------------------------------------------------
   // Clock, reset and DUT ports (all inputs known from time zero)
   // ---------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_operation  = OP_TICK;
   logic [INDEX_W-1:0]    req_pair_index = '0;
   logic [TONE_W-1:0]     req_tone_code  = '0;
   logic [HOLD_W-1:0]     req_hold_ticks = '0;
   logic [COUNT_W-1:0]    req_pair_count = '0;
   logic                  req_loop_flag  = 1'b0;
   logic                  rsp_valid;
   logic [DIVISOR_W-1:0]  rsp_timer_divisor;
   logic                  rsp_speaker_on;
   logic                  rsp_effect_active;
   logic                  rsp_background_active;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = CSR_TONE_BASE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   always #5 clock = ~clock;

   two_track_tone_sequencer dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_pair_index        (req_pair_index),
      .req_tone_code         (req_tone_code),
      .req_hold_ticks        (req_hold_ticks),
      .req_pair_count        (req_pair_count),
      .req_loop_flag         (req_loop_flag),
      .rsp_valid             (rsp_valid),
      .rsp_timer_divisor     (rsp_timer_divisor),
      .rsp_speaker_on        (rsp_speaker_on),
      .rsp_effect_active     (rsp_effect_active),
      .rsp_background_active (rsp_background_active),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // Sequencer model state: stores, per-track cursors, gate, divisor, CSRs
   // ---------------------------------------------------------------------
   logic [PAIR_W-1:0]      note_store   [2][NUM_PAIRS];
   bit                     note_written [2][NUM_PAIRS];
   int unsigned            track_pos  [2];
   int unsigned            track_hold [2];
   int unsigned            track_len  [2];
   bit                     bg_loops;
   bit                     gate_q;
   logic [DIVISOR_W-1:0]   divisor_q;
   logic [TONE_BASE_W-1:0] tone_base_q    = TONE_BASE_RST;
   logic [DIVISOR_W-1:0]   rest_divisor_q = REST_DIVISOR_RST;

   tone_state_type pending_tones [$];   // expected responses, oldest first
   stim_row_type   directed_rows [$];
   int          failures   = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          no_gaps    = 1'b0;
   int          setting_no = 0;

   // Divisor for a tone byte: rest drives rest_divisor, else base / tone
   // clipped to 16 bits (zero base gives zero).
   function automatic logic [DIVISOR_W-1:0] tone_divisor(logic [TONE_W-1:0] tone);
      int unsigned q;
      if (tone == '0)
         return rest_divisor_q;
      q = int'(tone_base_q) / int'(tone);
      return (q > DIV_SAT) ? DIVISOR_W'(DIV_SAT) : DIVISOR_W'(q);
   endfunction

   // One tick on the served track
   task automatic serve_track(int t);
      logic [PAIR_W-1:0] pair;
      if (track_pos[t] < track_len[t] ||
          (track_pos[t] == track_len[t] && track_hold[t] != 0)) begin
         if (track_hold[t] == 0) begin
            // take next pair: rest closes the gate
            pair       = note_store[t][track_pos[t]];
            gate_q     = (pair[PAIR_W-1 -: TONE_W] != '0);
            divisor_q  = tone_divisor(pair[PAIR_W-1 -: TONE_W]);
            track_pos[t]++;
            track_hold[t] = 32'(pair[HOLD_W-1:0]);
         end else begin
            // hold: re-drive current pair, gate untouched
            pair = (track_pos[t] != 0) ? note_store[t][track_pos[t]-1] : '0;
            track_hold[t]--;
            divisor_q = tone_divisor(pair[PAIR_W-1 -: TONE_W]);
         end
      end else if (t == BG_TRACK && bg_loops) begin
         track_pos[t] = 0;
      end else begin
         // track end; only the background end silences the speaker
         if (t == BG_TRACK)
            gate_q = 1'b0;
         track_len[t] = 0;
      end
   endtask

   // Apply one accepted transaction to the model, return the response
   task automatic advance_sequencer(input tone_req_type r, output tone_state_type res);
      int unsigned cnt;
      cnt = (32'(r.count) > NUM_PAIRS) ? NUM_PAIRS : 32'(r.count);
      case (r.op)
         OP_TICK:     serve_track((track_len[FX_TRACK] != 0) ? FX_TRACK : BG_TRACK);
         OP_WRITE_BG: begin
            note_store[BG_TRACK][r.idx]   = {r.tone, r.hold};
            note_written[BG_TRACK][r.idx] = 1'b1;
         end
         OP_WRITE_FX: begin
            note_store[FX_TRACK][r.idx]   = {r.tone, r.hold};
            note_written[FX_TRACK][r.idx] = 1'b1;
         end
         OP_START_BG: begin
            track_len[BG_TRACK]  = cnt;
            bg_loops             = r.loop_en;
            track_pos[BG_TRACK]  = 0;
            track_hold[BG_TRACK] = 0;
            gate_q               = 1'b1;
         end
         OP_START_FX: begin
            track_len[FX_TRACK]  = cnt;
            track_pos[FX_TRACK]  = 0;
            track_hold[FX_TRACK] = 0;
            gate_q               = 1'b1;
         end
         default: ;
      endcase
      res.divisor   = divisor_q;
      res.speaker   = gate_q;
      res.fx_active = (track_len[FX_TRACK] != 0);
      res.bg_active = (track_len[BG_TRACK] != 0);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [TONE_W-1:0] pick_tone();
      int r;
      r = $urandom_range(0, 19);
      if (r < 3)  return '0;           // rest
      if (r == 3) return '1;           // highest code, smallest divisor
      if (r == 4) return TONE_W'(1);   // lowest code, saturates
      return TONE_W'($urandom_range(1, 255));
   endfunction

   function automatic logic [HOLD_W-1:0] pick_hold();
      int r;
      r = $urandom_range(0, 19);
      if (r < 13) return HOLD_W'($urandom_range(0, 2));
      if (r < 18) return HOLD_W'($urandom_range(3, 8));
      if (r == 18) return '1;
      return HOLD_W'($urandom_range(0, 255));
   endfunction

   // Unused fields carry random bits so every port bit toggles
   function automatic tone_req_type random_req(logic [OP_W-1:0] op);
      tone_req_type r;
      r.op      = op;
      r.idx     = INDEX_W'($urandom_range(0, 2**INDEX_W - 1));
      r.tone    = TONE_W'($urandom_range(0, 2**TONE_W - 1));
      r.hold    = HOLD_W'($urandom_range(0, 2**HOLD_W - 1));
      r.count   = COUNT_W'($urandom_range(0, 2**COUNT_W - 1));
      r.loop_en = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Drive one request; it is taken at the first edge with start high and
   // busy low. busy is sampled at the falling edge, so the edge that follows
   // is the accepting one. The expectation is queued at that edge.
   task automatic send_raw(input tone_req_type r, input bit has_exp,
                           input tone_state_type exp);
      int             gap;
      tone_state_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_operation  <= r.op;
      req_pair_index <= r.idx;
      req_tone_code  <= r.tone;
      req_hold_ticks <= r.hold;
      req_pair_count <= r.count;
      req_loop_flag  <= r.loop_en;
      do @(negedge clock); while (busy !== 1'b0);
      @(posedge clock);
      advance_sequencer(r, predicted);
      pending_tones.push_back(has_exp ? exp : predicted);
      items_sent++;
   endtask

   // A tick that would take a never-written pair gets that pair written first
   task automatic fill_ahead();
      int           t;
      tone_req_type w;
      t = (track_len[FX_TRACK] != 0) ? FX_TRACK : BG_TRACK;
      if (track_hold[t] == 0 && track_pos[t] < track_len[t] &&
          !note_written[t][track_pos[t]]) begin
         w      = random_req((t == BG_TRACK) ? OP_WRITE_BG : OP_WRITE_FX);
         w.idx  = INDEX_W'(track_pos[t]);
         w.tone = pick_tone();
         w.hold = pick_hold();
         send_raw(w, 1'b0, '0);
      end
   endtask

   task automatic send_item(input tone_req_type r, input bit has_exp,
                            input tone_state_type exp);
      if (r.op == OP_TICK)
         fill_ahead();
      send_raw(r, has_exp, exp);
   endtask

   // Stop sending and let every outstanding response drain
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_tones.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // Both CSRs on consecutive cycles; write enable stays high across them
   task automatic apply_setting(logic [TONE_BASE_W-1:0] base,
                                logic [DIVISOR_W-1:0] rest);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_TONE_BASE;
      csr_write_data <= base;
      @(posedge clock);
      tone_base_q     = base;
      csr_index      <= CSR_REST_DIVISOR;
      csr_write_data <= CSR_DATA_W'(rest);
      @(posedge clock);
      rest_divisor_q  = rest;
      csr_write_en   <= 1'b0;
   endtask

   // Walk through the extremes first, then random settings
   task automatic change_setting();
      logic [DIVISOR_W-1:0] rnd_rest;
      int                   pick;
      rnd_rest = DIVISOR_W'($urandom_range(0, DIV_SAT));
      pick = (setting_no < 6) ? setting_no : $urandom_range(0, 5);
      setting_no++;
      wait_idle();
      case (pick)
         0: apply_setting('0, DIVISOR_W'(DIV_SAT));              // zero base
         1: apply_setting(TONE_BASE_W'(1), '0);
         2: apply_setting(TONE_BASE_W'(TONE_BASE_MAX), rnd_rest);
         3: apply_setting(TONE_BASE_W'($urandom_range(1, TONE_BASE_MAX)), rnd_rest);
         4: apply_setting(TONE_BASE_W'($urandom_range(1, 300)), rnd_rest);
         default: apply_setting(TONE_BASE_RST, REST_DIVISOR_RST);
      endcase
   endtask

   // Well-formed song: write pairs 0..n-1, start the track, tick it out (at most 40 ticks)
   task automatic play_song();
      int           trk, n, ticks;
      tone_req_type r;
      trk   = $urandom_range(BG_TRACK, FX_TRACK);
      n     = $urandom_range(1, 6);
      ticks = 2;
      for (int i = 0; i < n; i++) begin
         r      = random_req((trk == BG_TRACK) ? OP_WRITE_BG : OP_WRITE_FX);
         r.idx  = INDEX_W'(i);
         r.tone = pick_tone();
         r.hold = pick_hold();
         ticks += int'(r.hold) + 1;
         send_item(r, 1'b0, '0);
      end
      r       = random_req((trk == BG_TRACK) ? OP_START_BG : OP_START_FX);
      r.count = COUNT_W'(n);
      send_item(r, 1'b0, '0);
      if (ticks > 40)
         ticks = 40;
      for (int i = 0; i < ticks; i++)
         send_item(random_req(OP_TICK), 1'b0, '0);
   endtask

   task automatic add_row(logic [OP_W-1:0] op, int idx, int tone, int hold,
                          int count, bit loop_en, bit has_exp, tone_state_type exp);
      stim_row_type row;
      row.req.op      = op;
      row.req.idx     = INDEX_W'(idx);
      row.req.tone    = TONE_W'(tone);
      row.req.hold    = HOLD_W'(hold);
      row.req.count   = COUNT_W'(count);
      row.req.loop_en = loop_en;
      row.has_exp     = has_exp;
      row.exp         = exp;
      directed_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------------
   // Response scoreboard: strobe and fields are stable at the falling edge
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [DIVISOR_W-1:0] want,
                                       logic [DIVISOR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(negedge clock) begin
      tone_state_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_tones.size() == 0) begin
            $error("response with no transaction outstanding");
            failures++;
         end else begin
            want = pending_tones.pop_front();
            check_field("timer_divisor", want.divisor, rsp_timer_divisor);
            check_field("speaker_on", DIVISOR_W'(want.speaker),
                        DIVISOR_W'(rsp_speaker_on));
            check_field("effect_active", DIVISOR_W'(want.fx_active),
                        DIVISOR_W'(rsp_effect_active));
            check_field("background_active", DIVISOR_W'(want.bg_active),
                        DIVISOR_W'(rsp_background_active));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main flow
   // ---------------------------------------------------------------------
   initial begin
      int             random_goal;
      int             next_setting_at;
      int             burst;
      tone_req_type   r;
      tone_state_type quiet, bg_started;

      quiet      = '0;
      bg_started = tone_state_type'({DIVISOR_W'(0), 1'b1, 1'b0, 1'b1});

      // Directed table. Typed expectations only where obvious; the rest
      // are scored against the model. Background song: rest, top tone,
      // bottom tone (saturating), looped; then a one-pair effect over it.
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b1, quiet);  // idle tick
      add_row(OP_SPARE_LO,  0,   0,   0, 0, 1'b0, 1'b1, quiet);  // no-op codes
      add_row(OP_SPARE_HI,  511, 255, 255, 1023, 1'b1, 1'b1, quiet);
      add_row(OP_WRITE_BG,  0,   0,   1, 0, 1'b0, 1'b1, quiet);  // rest
      add_row(OP_WRITE_BG,  1,   255, 0, 0, 1'b0, 1'b1, quiet);
      add_row(OP_WRITE_BG,  2,   1,   2, 0, 1'b0, 1'b1, quiet);
      add_row(OP_START_BG,  0,   0,   0, 3, 1'b1, 1'b1, bg_started);
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b1,
              tone_state_type'({REST_DIVISOR_RST, 1'b0, 1'b0, 1'b1}));
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);  // rest held
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);  // top tone
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b1,
              tone_state_type'({DIVISOR_W'(DIV_SAT), 1'b1, 1'b0, 1'b1}));
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);  // loop rewind
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);  // first pair again
      add_row(OP_WRITE_FX,  0,   128, 0, 0, 1'b0, 1'b0, quiet);
      add_row(OP_WRITE_FX,  511, 255, 255, 0, 1'b0, 1'b0, quiet); // top index
      add_row(OP_START_FX,  0,   0,   0, 1, 1'b0, 1'b0, quiet);
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);  // effect note
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);  // effect end
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);  // back to bg
      add_row(OP_START_BG,  0,   0,   0, 0, 1'b0, 1'b0, quiet);  // empty track
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);  // bg end closes gate
      add_row(OP_TICK,      0,   0,   0, 0, 1'b0, 1'b0, quiet);  // still closed
      add_row(OP_START_FX,  0,   0,   0, 0, 1'b0, 1'b0, quiet);

      // Hold synchronous reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      no_gaps = 1'b0;
      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].has_exp, directed_rows[i].exp);

      // Random part: mostly songs, plus long starts, noise, drains and
      // register changes (extremes first).
      random_goal     = items_sent + RANDOM_ITEMS;
      next_setting_at = items_sent;
      while (items_sent < random_goal) begin
         if (items_sent >= next_setting_at) begin
            change_setting();
            next_setting_at = items_sent + SETTING_EVERY;
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5, 6: play_song();
            7: begin
               // long or oversized count, a few ticks
               r = random_req($urandom_range(0, 1) ? OP_START_BG : OP_START_FX);
               case ($urandom_range(0, 2))
                  0: r.count = COUNT_W'(NUM_PAIRS);
                  1: r.count = '1;
                  default: r.count = COUNT_W'($urandom_range(NUM_PAIRS + 1, 1023));
               endcase
               send_item(r, 1'b0, '0);
               burst = $urandom_range(1, 8);
               for (int i = 0; i < burst; i++)
                  send_item(random_req(OP_TICK), 1'b0, '0);
            end
            8, 9: begin
               // noise: any code, any field values, ticks favored
               burst = $urandom_range(3, 10);
               for (int i = 0; i < burst; i++)
                  send_item(random_req($urandom_range(0, 2) == 0 ?
                                       OP_W'($urandom_range(0, 7)) : OP_TICK),
                            1'b0, '0);
            end
            10: wait_idle();
            default: change_setting();
         endcase
      end

      // Drain, then allow the slowest transaction's latency once more
      start <= 1'b0;
      while (pending_tones.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_tones.size() != 0) begin
         $error("%0d responses never arrived", pending_tones.size());
         failures++;
      end

      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
